[rtl/ohte_pkg.sv]
package ohte_pkg;

   // Fixed field widths of the request and response channels
   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int HASH_W   = 32;
   localparam int VAL_W    = 32;
   localparam int CUR_W    = 11;
   localparam int STS_W    = 2;

   // Default table sizes and the smallest index capacity
   localparam int INDEX_SLOTS_DEF = 1024;
   localparam int ENTRY_SLOTS_DEF = 1024;
   localparam int MIN_CAP         = 8;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ITER   = 2'd3
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK     = 2'd0,
      STS_ABSENT = 2'd1,
      STS_FULL   = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_PRB_START,
      ST_PRB_RD,
      ST_PRB_SLOT,
      ST_PRB_ENT,
      ST_DISPATCH,
      ST_INS_CHK,
      ST_CAP_CALC,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_CLR,
      ST_RIX_RD,
      ST_RIX_HASH,
      ST_RIX_CHK,
      ST_INS_WR,
      ST_ITR_RD,
      ST_ITR_CHK,
      ST_RESP
   } state_type;

   // Outcome of the shared slot and key compare unit
   typedef struct packed {
      logic empty;
      logic tomb;
      logic hit;
   } match_type;

endpackage

[rtl/ohte_ram.sv]
module ohte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ohte_match.sv]
module ohte_match #(
   parameter int SLOT_W = 11
) (
   input  logic [SLOT_W-1:0]        slot_word,
   input  logic [ohte_pkg::HASH_W-1:0] probe_hash,
   input  logic [ohte_pkg::KEY_W-1:0]  probe_key,
   input  logic [ohte_pkg::HASH_W-1:0] ent_hash,
   input  logic [ohte_pkg::KEY_W-1:0]  ent_key,
   output ohte_pkg::match_type       result
);

   localparam logic [SLOT_W-1:0] SlotEmpty = '1;
   localparam logic [SLOT_W-1:0] SlotTomb  = {{(SLOT_W-1){1'b1}}, 1'b0};

   // Classify the slot word and compare the stored entry against the probe
   always_comb begin
      result.empty = (slot_word == SlotEmpty);
      result.tomb  = (slot_word == SlotTomb);
      result.hit   = (ent_hash == probe_hash) && (ent_key == probe_key);
   end

endmodule

[rtl/ordered_hash_table_engine_unit.sv]
// Lookup, delete and update pass through probe start, then a slot read and check per probed
// slot, plus an entry read and compare for each slot holding an entry, then dispatch and response.
// Iterate reads and checks entries from the cursor until a live one is found or the scan runs out.
// Insert of a new key adds an append check and write; a rebuild sizes the index, compacts the
// stored entries, clears the index slots and re-indexes every live entry. Throughput: one operation
// at a time, next transfer once the result is in the response register. Reset: synchronous; index swept.
module ordered_hash_table_engine_unit #(
   parameter int INDEX_SLOTS = ohte_pkg::INDEX_SLOTS_DEF,
   parameter int ENTRY_SLOTS = ohte_pkg::ENTRY_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ohte_pkg::OP_W-1:0]   req_op,
   input  logic [ohte_pkg::KEY_W-1:0]  req_key,
   input  logic [ohte_pkg::HASH_W-1:0] req_key_hash,
   input  logic [ohte_pkg::VAL_W-1:0]  req_value,
   input  logic [ohte_pkg::CUR_W-1:0]  req_cursor,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ohte_pkg::STS_W-1:0]  rsp_status,
   output logic                        rsp_found,
   output logic [ohte_pkg::KEY_W-1:0]  rsp_key_out,
   output logic [ohte_pkg::VAL_W-1:0]  rsp_value_out,
   output logic [ohte_pkg::CUR_W-1:0]  rsp_next_cursor,
   output logic [ohte_pkg::CUR_W-1:0]  rsp_live_count
);

   localparam int IW  = $clog2(INDEX_SLOTS);
   localparam int EW  = $clog2(ENTRY_SLOTS);
   localparam int SW  = EW + 1;
   localparam int CW0 = $clog2(ENTRY_SLOTS + 1);
   localparam int CW  = (CW0 > ohte_pkg::CUR_W) ? CW0 : ohte_pkg::CUR_W;
   localparam int PW  = IW + 2;
   localparam int MW  = ((CW > PW) ? CW : PW) + 3;
   localparam int KHW = ohte_pkg::KEY_W + ohte_pkg::HASH_W;

   localparam logic [SW-1:0] SlotEmpty = '1;
   localparam logic [SW-1:0] SlotTomb  = {{(SW-1){1'b1}}, 1'b0};

   // Control and bookkeeping registers
   ohte_pkg::state_type state_ff, state_in;
   ohte_pkg::op_type    op_ff, op_in;
   logic [ohte_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [ohte_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [ohte_pkg::VAL_W-1:0]  value_ff, value_in;
   logic [CW-1:0] order_count_ff, order_count_in;
   logic [CW-1:0] alive_total_ff, alive_total_in;
   logic [PW-1:0] cap_ff, cap_in;
   logic [PW-1:0] ncap_ff, ncap_in;
   logic [PW-1:0] step_ff, step_in;
   logic [IW-1:0] pi_ff, pi_in;
   logic          tomb_v_ff, tomb_v_in;
   logic [IW-1:0] tomb_ff, tomb_in;
   logic          found_ff, found_in;
   logic [IW-1:0] where_ff, where_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic [ohte_pkg::VAL_W-1:0] pval_ff, pval_in;
   logic          rebuilt_ff, rebuilt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cj_ff, cj_in;
   logic [IW:0]   clr_ff, clr_in;
   logic [IW-1:0] rs_ff, rs_in;

   // Result holding and response registers
   ohte_pkg::status_type res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [ohte_pkg::KEY_W-1:0] res_key_ff, res_key_in;
   logic [ohte_pkg::VAL_W-1:0] res_val_ff, res_val_in;
   logic [CW-1:0]        res_ncur_ff, res_ncur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ohte_pkg::STS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [ohte_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [ohte_pkg::VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [ohte_pkg::CUR_W-1:0] rsp_ncur_ff, rsp_ncur_in;
   logic [ohte_pkg::CUR_W-1:0] rsp_live_ff, rsp_live_in;

   // Memory ports
   logic          s_we;
   logic [IW-1:0] s_wa, s_ra;
   logic [SW-1:0] s_wd, s_rd;
   logic          kh_we;
   logic [EW-1:0] kh_wa, kh_ra;
   logic [KHW-1:0] kh_wd, kh_rd;
   logic          v_we;
   logic [EW-1:0] v_wa, v_ra;
   logic [ohte_pkg::VAL_W-1:0] v_wd, v_rd;
   logic          a_we;
   logic [EW-1:0] a_wa, a_ra;
   logic [0:0]    a_wd, a_rd;

   ohte_pkg::match_type m;
   logic [IW-1:0] mask;
   logic [PW-1:0] cap_m1;
   logic [MW-1:0] due_lhs, due_rhs, dead_lim, want;
   logic          due;
   logic          last_step;

   ohte_ram #(.WIDTH(SW), .DEPTH(INDEX_SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd)
   );

   ohte_ram #(.WIDTH(KHW), .DEPTH(ENTRY_SLOTS)) u_kh_ram (
      .clock(clock), .wr_en(kh_we), .wr_addr(kh_wa), .wr_data(kh_wd),
      .rd_addr(kh_ra), .rd_data(kh_rd)
   );

   ohte_ram #(.WIDTH(ohte_pkg::VAL_W), .DEPTH(ENTRY_SLOTS)) u_val_ram (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd)
   );

   ohte_ram #(.WIDTH(1), .DEPTH(ENTRY_SLOTS)) u_alive_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
      .rd_addr(a_ra), .rd_data(a_rd)
   );

   ohte_match #(.SLOT_W(SW)) u_match (
      .slot_word (s_rd),
      .probe_hash(hash_ff),
      .probe_key (key_ff),
      .ent_hash  (kh_rd[ohte_pkg::HASH_W-1:0]),
      .ent_key   (kh_rd[KHW-1:ohte_pkg::HASH_W]),
      .result    (m)
   );

   // Capacity mask and rebuild trigger arithmetic
   always_comb begin
      cap_m1   = cap_ff - PW'(1);
      mask     = cap_m1[IW-1:0];
      due_lhs  = (MW'(order_count_ff) + MW'(1)) * MW'(3);
      due_rhs  = MW'(cap_ff) * MW'(2);
      dead_lim = MW'(alive_total_ff) * MW'(2) + MW'(8);
      due      = (due_lhs >= due_rhs) || (MW'(order_count_ff) > dead_lim);
      want     = (MW'(alive_total_ff) + MW'(1)) * MW'(2);
      last_step = (step_ff == cap_m1);
   end

   // Sequencer: next state, memory commands and result capture
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      hash_in        = hash_ff;
      value_in       = value_ff;
      order_count_in = order_count_ff;
      alive_total_in = alive_total_ff;
      cap_in         = cap_ff;
      ncap_in        = ncap_ff;
      step_in        = step_ff;
      pi_in          = pi_ff;
      tomb_v_in      = tomb_v_ff;
      tomb_in        = tomb_ff;
      found_in       = found_ff;
      where_in       = where_ff;
      ent_in         = ent_ff;
      pval_in        = pval_ff;
      rebuilt_in     = rebuilt_ff;
      idx_in         = idx_ff;
      cj_in          = cj_ff;
      clr_in         = clr_ff;
      rs_in          = rs_ff;
      res_status_in  = res_status_ff;
      res_found_in   = res_found_ff;
      res_key_in     = res_key_ff;
      res_val_in     = res_val_ff;
      res_ncur_in    = res_ncur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_val_in     = rsp_val_ff;
      rsp_ncur_in    = rsp_ncur_ff;
      rsp_live_in    = rsp_live_ff;
      req_ready      = 1'b0;
      s_we  = 1'b0; s_wa  = '0; s_wd  = '0; s_ra  = '0;
      kh_we = 1'b0; kh_wa = '0; kh_wd = '0; kh_ra = '0;
      v_we  = 1'b0; v_wa  = '0; v_wd  = '0; v_ra  = '0;
      a_we  = 1'b0; a_wa  = '0; a_wd  = '0; a_ra  = '0;

      case (state_ff)
         // Sweep the whole index to empty after reset
         ohte_pkg::ST_INIT: begin
            s_we   = 1'b1;
            s_wa   = clr_ff[IW-1:0];
            s_wd   = SlotEmpty;
            clr_in = clr_ff + (IW+1)'(1);
            if (clr_ff == (IW+1)'(INDEX_SLOTS - 1)) begin
               clr_in   = '0;
               state_in = ohte_pkg::ST_IDLE;
            end
         end

         // Take a request transfer
         ohte_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = ohte_pkg::op_type'(req_op);
               key_in     = req_key;
               hash_in    = req_key_hash;
               value_in   = req_value;
               rebuilt_in = 1'b0;
               if (ohte_pkg::op_type'(req_op) == ohte_pkg::OP_ITER) begin
                  idx_in   = CW'(req_cursor);
                  state_in = ohte_pkg::ST_ITR_RD;
               end else begin
                  state_in = ohte_pkg::ST_PRB_START;
               end
            end
         end

         // Start a linear probe at the masked hash
         ohte_pkg::ST_PRB_START: begin
            tomb_v_in = 1'b0;
            step_in   = '0;
            pi_in     = hash_ff[IW-1:0] & mask;
            if (cap_ff == '0) begin
               found_in = 1'b0;
               where_in = '0;
               state_in = ohte_pkg::ST_DISPATCH;
            end else begin
               state_in = ohte_pkg::ST_PRB_RD;
            end
         end

         ohte_pkg::ST_PRB_RD: begin
            s_ra     = pi_ff;
            state_in = ohte_pkg::ST_PRB_SLOT;
         end

         // Inspect the slot: stop on empty, note a tombstone, else fetch the entry
         ohte_pkg::ST_PRB_SLOT: begin
            if (m.empty) begin
               found_in = 1'b0;
               where_in = tomb_v_ff ? tomb_ff : pi_ff;
               state_in = ohte_pkg::ST_DISPATCH;
            end else if (m.tomb) begin
               if (!tomb_v_ff) begin
                  tomb_v_in = 1'b1;
                  tomb_in   = pi_ff;
               end
               pi_in   = (pi_ff + IW'(1)) & mask;
               step_in = step_ff + PW'(1);
               if (last_step) begin
                  found_in = 1'b0;
                  where_in = tomb_v_in ? tomb_in : '0;
                  state_in = ohte_pkg::ST_DISPATCH;
               end else begin
                  state_in = ohte_pkg::ST_PRB_RD;
               end
            end else begin
               kh_ra    = s_rd[EW-1:0];
               v_ra     = s_rd[EW-1:0];
               ent_in   = s_rd[EW-1:0];
               state_in = ohte_pkg::ST_PRB_ENT;
            end
         end

         // Compare hash and key of the fetched entry
         ohte_pkg::ST_PRB_ENT: begin
            if (m.hit) begin
               found_in = 1'b1;
               where_in = pi_ff;
               pval_in  = v_rd;
               state_in = ohte_pkg::ST_DISPATCH;
            end else begin
               pi_in   = (pi_ff + IW'(1)) & mask;
               step_in = step_ff + PW'(1);
               if (last_step) begin
                  found_in = 1'b0;
                  where_in = tomb_v_ff ? tomb_ff : '0;
                  state_in = ohte_pkg::ST_DISPATCH;
               end else begin
                  state_in = ohte_pkg::ST_PRB_RD;
               end
            end
         end

         // Act on the probe outcome
         ohte_pkg::ST_DISPATCH: begin
            res_key_in   = '0;
            res_ncur_in  = '0;
            res_val_in   = '0;
            res_found_in = found_ff;
            res_status_in = found_ff ? ohte_pkg::STS_OK : ohte_pkg::STS_ABSENT;
            state_in     = ohte_pkg::ST_RESP;
            case (op_ff)
               ohte_pkg::OP_LOOKUP: begin
                  if (found_ff) begin
                     res_val_in = pval_ff;
                  end
               end
               ohte_pkg::OP_DELETE: begin
                  if (found_ff) begin
                     res_val_in = pval_ff;
                     s_we = 1'b1; s_wa = where_ff; s_wd = SlotTomb;
                     a_we = 1'b1; a_wa = ent_ff;   a_wd = 1'b0;
                     if (alive_total_ff != '0) begin
                        alive_total_in = alive_total_ff - CW'(1);
                     end
                  end
               end
               ohte_pkg::OP_INSERT: begin
                  res_status_in = ohte_pkg::STS_OK;
                  if (found_ff) begin
                     v_we = 1'b1; v_wa = ent_ff; v_wd = value_ff;
                  end else if (rebuilt_ff) begin
                     state_in = ohte_pkg::ST_INS_WR;
                  end else begin
                     state_in = ohte_pkg::ST_INS_CHK;
                  end
               end
               default: begin
                  state_in = ohte_pkg::ST_RESP;
               end
            endcase
         end

         // Decide between rebuild, full and a plain append
         ohte_pkg::ST_INS_CHK: begin
            if (due) begin
               ncap_in  = PW'(ohte_pkg::MIN_CAP);
               state_in = ohte_pkg::ST_CAP_CALC;
            end else if (order_count_ff >= CW'(ENTRY_SLOTS)) begin
               res_status_in = ohte_pkg::STS_FULL;
               res_found_in  = 1'b0;
               state_in      = ohte_pkg::ST_RESP;
            end else begin
               state_in = ohte_pkg::ST_INS_WR;
            end
         end

         // Double the new capacity until it covers twice the sum of the live count and one
         ohte_pkg::ST_CAP_CALC: begin
            if ((MW'(ncap_ff) < want) && (ncap_ff <= PW'(INDEX_SLOTS))) begin
               ncap_in = ncap_ff << 1;
            end else if ((ncap_ff > PW'(INDEX_SLOTS)) ||
                         (alive_total_ff >= CW'(ENTRY_SLOTS))) begin
               res_status_in = ohte_pkg::STS_FULL;
               res_found_in  = 1'b0;
               state_in      = ohte_pkg::ST_RESP;
            end else begin
               cap_in   = ncap_ff;
               idx_in   = '0;
               cj_in    = '0;
               state_in = ohte_pkg::ST_CMP_RD;
            end
         end

         // Compact live entries to the front of the order store
         ohte_pkg::ST_CMP_RD: begin
            if (idx_ff < order_count_ff) begin
               kh_ra    = idx_ff[EW-1:0];
               v_ra     = idx_ff[EW-1:0];
               a_ra     = idx_ff[EW-1:0];
               state_in = ohte_pkg::ST_CMP_WR;
            end else begin
               order_count_in = cj_ff;
               clr_in         = '0;
               state_in       = ohte_pkg::ST_CLR;
            end
         end

         ohte_pkg::ST_CMP_WR: begin
            if (a_rd[0]) begin
               kh_we = 1'b1; kh_wa = cj_ff[EW-1:0]; kh_wd = kh_rd;
               v_we  = 1'b1; v_wa  = cj_ff[EW-1:0]; v_wd  = v_rd;
               a_we  = 1'b1; a_wa  = cj_ff[EW-1:0]; a_wd  = 1'b1;
               cj_in = cj_ff + CW'(1);
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ohte_pkg::ST_CMP_RD;
         end

         // Empty the slots of the new capacity
         ohte_pkg::ST_CLR: begin
            s_we   = 1'b1;
            s_wa   = clr_ff[IW-1:0];
            s_wd   = SlotEmpty;
            clr_in = clr_ff + (IW+1)'(1);
            if (clr_ff == cap_m1[IW:0]) begin
               clr_in   = '0;
               idx_in   = '0;
               state_in = ohte_pkg::ST_RIX_RD;
            end
         end

         // Re-index every compacted entry
         ohte_pkg::ST_RIX_RD: begin
            if (idx_ff < order_count_ff) begin
               kh_ra    = idx_ff[EW-1:0];
               state_in = ohte_pkg::ST_RIX_HASH;
            end else begin
               rebuilt_in = 1'b1;
               state_in   = ohte_pkg::ST_PRB_START;
            end
         end

         ohte_pkg::ST_RIX_HASH: begin
            rs_in    = kh_rd[IW-1:0] & mask;
            s_ra     = rs_in;
            state_in = ohte_pkg::ST_RIX_CHK;
         end

         ohte_pkg::ST_RIX_CHK: begin
            if (m.empty) begin
               s_we     = 1'b1;
               s_wa     = rs_ff;
               s_wd     = {1'b0, idx_ff[EW-1:0]};
               idx_in   = idx_ff + CW'(1);
               state_in = ohte_pkg::ST_RIX_RD;
            end else begin
               rs_in = (rs_ff + IW'(1)) & mask;
               s_ra  = rs_in;
            end
         end

         // Append the new entry and point its slot at it
         ohte_pkg::ST_INS_WR: begin
            kh_we = 1'b1; kh_wa = order_count_ff[EW-1:0]; kh_wd = {key_ff, hash_ff};
            v_we  = 1'b1; v_wa  = order_count_ff[EW-1:0]; v_wd  = value_ff;
            a_we  = 1'b1; a_wa  = order_count_ff[EW-1:0]; a_wd  = 1'b1;
            s_we  = 1'b1; s_wa  = where_ff; s_wd = {1'b0, order_count_ff[EW-1:0]};
            order_count_in = order_count_ff + CW'(1);
            alive_total_in = alive_total_ff + CW'(1);
            res_status_in  = ohte_pkg::STS_OK;
            res_found_in   = 1'b0;
            res_key_in     = '0;
            res_val_in     = '0;
            res_ncur_in    = '0;
            state_in       = ohte_pkg::ST_RESP;
         end

         // Scan forward from the cursor for a live entry
         ohte_pkg::ST_ITR_RD: begin
            if (idx_ff < order_count_ff) begin
               kh_ra    = idx_ff[EW-1:0];
               v_ra     = idx_ff[EW-1:0];
               a_ra     = idx_ff[EW-1:0];
               state_in = ohte_pkg::ST_ITR_CHK;
            end else begin
               res_status_in = ohte_pkg::STS_ABSENT;
               res_found_in  = 1'b0;
               res_key_in    = '0;
               res_val_in    = '0;
               res_ncur_in   = idx_ff;
               state_in      = ohte_pkg::ST_RESP;
            end
         end

         ohte_pkg::ST_ITR_CHK: begin
            idx_in = idx_ff + CW'(1);
            if (a_rd[0]) begin
               res_status_in = ohte_pkg::STS_OK;
               res_found_in  = 1'b1;
               res_key_in    = kh_rd[KHW-1:ohte_pkg::HASH_W];
               res_val_in    = v_rd;
               res_ncur_in   = idx_ff + CW'(1);
               state_in      = ohte_pkg::ST_RESP;
            end else begin
               state_in = ohte_pkg::ST_ITR_RD;
            end
         end

         // Hand the result to the response register once it is free
         ohte_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_key_in    = res_key_ff;
               rsp_val_in    = res_val_ff;
               rsp_ncur_in   = res_ncur_ff[ohte_pkg::CUR_W-1:0];
               rsp_live_in   = alive_total_ff[ohte_pkg::CUR_W-1:0];
               state_in      = ohte_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ohte_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ohte_pkg::ST_INIT;
         clr_ff         <= '0;
         order_count_ff <= '0;
         alive_total_ff <= '0;
         cap_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         order_count_ff <= order_count_in;
         alive_total_ff <= alive_total_in;
         cap_ff         <= cap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      value_ff      <= value_in;
      ncap_ff       <= ncap_in;
      step_ff       <= step_in;
      pi_ff         <= pi_in;
      tomb_v_ff     <= tomb_v_in;
      tomb_ff       <= tomb_in;
      found_ff      <= found_in;
      where_ff      <= where_in;
      ent_ff        <= ent_in;
      pval_ff       <= pval_in;
      rebuilt_ff    <= rebuilt_in;
      idx_ff        <= idx_in;
      cj_ff         <= cj_in;
      rs_ff         <= rs_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      res_ncur_ff   <= res_ncur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_ncur_ff   <= rsp_ncur_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_value_out   = rsp_val_ff;
   assign rsp_next_cursor = rsp_ncur_ff;
   assign rsp_live_count  = rsp_live_ff;

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_live_le_order: assert property (@(posedge clock) disable iff (reset)
      alive_total_ff <= order_count_ff)
      else $error("live count exceeds order store fill");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      cap_ff <= PW'(INDEX_SLOTS))
      else $error("index capacity beyond index memory");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ohte_pkg::STS_FULL) |-> !rsp_found)
      else $error("full response marks a found key");
`endif

endmodule

[bench/testbench.sv]
module testbench;

   localparam int SLOT_CAP  = ohte_pkg::INDEX_SLOTS_DEF;
   localparam int ENTRY_CAP = ohte_pkg::ENTRY_SLOTS_DEF;
   localparam int EMPTY_MARK = -1;
   localparam int TOMB_MARK  = -2;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      ohte_pkg::op_type op;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] value;
      logic [10:0] cursor;
   } request_type;

   typedef struct {
      ohte_pkg::status_type status;
      logic        found;
      logic [31:0] key_out;
      logic [31:0] value_out;
      logic [10:0] next_cursor;
      logic [10:0] live_count;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [ohte_pkg::OP_W-1:0] req_op = '0;
   logic [ohte_pkg::KEY_W-1:0] req_key = '0;
   logic [ohte_pkg::HASH_W-1:0] req_key_hash = '0;
   logic [ohte_pkg::VAL_W-1:0] req_value = '0;
   logic [ohte_pkg::CUR_W-1:0] req_cursor = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [ohte_pkg::STS_W-1:0] rsp_status;
   logic rsp_found;
   logic [ohte_pkg::KEY_W-1:0] rsp_key_out;
   logic [ohte_pkg::VAL_W-1:0] rsp_value_out;
   logic [ohte_pkg::CUR_W-1:0] rsp_next_cursor;
   logic [ohte_pkg::CUR_W-1:0] rsp_live_count;

   ordered_hash_table_engine_unit dut (.*);

   always #4 clock = ~clock;

   // Shadow table state
   int slots [SLOT_CAP];
   logic [31:0] ent_key [ENTRY_CAP];
   logic [31:0] ent_val [ENTRY_CAP];
   logic [31:0] ent_hash [ENTRY_CAP];
   bit ent_live [ENTRY_CAP];
   int order_len, live_len, capacity;

   request_type pending_reqs[$];
   answer_type  expected_answers[$];
   int mismatches = 0;
   int send_idle_pct = 23, recv_idle_pct = 59;
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_count = 0;
   int cycles = 0;
   // keys used so far, to revisit them
   logic [31:0] used_keys[$];

   function automatic bit find_slot(input logic [31:0] k, input logic [31:0] h,
                                    output int where, output int ent);
      int mask, i, tomb;
      where = 0; ent = 0;
      if (capacity == 0) return 0;
      mask = capacity - 1;
      i = h & mask;
      tomb = capacity;
      for (int n = 0; n < capacity; n++) begin
         if (slots[i] == EMPTY_MARK) begin
            where = (tomb < capacity) ? tomb : i;
            return 0;
         end
         if (slots[i] == TOMB_MARK) begin
            if (tomb == capacity) tomb = i;
         end else if (ent_hash[slots[i]] == h && ent_key[slots[i]] == k) begin
            where = i; ent = slots[i];
            return 1;
         end
         i = (i + 1) & mask;
      end
      where = (tomb < capacity) ? tomb : 0;
      return 0;
   endfunction

   function automatic void reindex(input int cap);
      int j, s;
      j = 0;
      for (int i = 0; i < order_len; i++)
         if (ent_live[i]) begin
            ent_key[j] = ent_key[i]; ent_val[j] = ent_val[i];
            ent_hash[j] = ent_hash[i]; ent_live[j] = 1;
            j++;
         end
      order_len = j;
      for (int i = 0; i < cap; i++) slots[i] = EMPTY_MARK;
      for (int i = 0; i < j; i++) begin
         s = ent_hash[i] & (cap - 1);
         while (slots[s] != EMPTY_MARK) s = (s + 1) & (cap - 1);
         slots[s] = i;
      end
      capacity = cap;
   endfunction

   function automatic answer_type table_apply(input request_type r);
      answer_type a;
      int where, ent, cap, at;
      bit hit, due;
      a = '{ohte_pkg::STS_OK, 0, 0, 0, 0, 0};
      case (r.op)
         ohte_pkg::OP_LOOKUP, ohte_pkg::OP_DELETE: begin
            if (find_slot(r.key, r.key_hash, where, ent)) begin
               a.found = 1;
               a.value_out = ent_val[ent];
               if (r.op == ohte_pkg::OP_DELETE) begin
                  slots[where] = TOMB_MARK;
                  ent_live[ent] = 0;
                  if (live_len > 0) live_len--;
               end
            end else a.status = ohte_pkg::STS_ABSENT;
         end
         ohte_pkg::OP_INSERT: begin
            if (find_slot(r.key, r.key_hash, where, ent)) begin
               ent_val[ent] = r.value;
               a.found = 1;
            end else begin
               due = (order_len + 1) * 3 >= capacity * 2 || order_len > live_len * 2 + 8;
               if (due) begin
                  cap = ohte_pkg::MIN_CAP;
                  while (cap < (live_len + 1) * 2 && cap <= SLOT_CAP) cap *= 2;
                  if (cap > SLOT_CAP || live_len >= ENTRY_CAP) a.status = ohte_pkg::STS_FULL;
                  else begin
                     reindex(cap);
                     void'(find_slot(r.key, r.key_hash, where, ent));
                  end
               end else if (order_len >= ENTRY_CAP) a.status = ohte_pkg::STS_FULL;
               if (a.status == ohte_pkg::STS_OK && order_len < ENTRY_CAP) begin
                  ent_key[order_len] = r.key; ent_val[order_len] = r.value;
                  ent_hash[order_len] = r.key_hash; ent_live[order_len] = 1;
                  slots[where] = order_len;
                  order_len++; live_len++;
               end
            end
         end
         default: begin
            at = int'(r.cursor); hit = 0;
            while (at < order_len) begin
               at++;
               if (ent_live[at-1]) begin
                  a.key_out = ent_key[at-1]; a.value_out = ent_val[at-1];
                  hit = 1;
                  break;
               end
            end
            if (hit) a.found = 1;
            else a.status = ohte_pkg::STS_ABSENT;
            a.next_cursor = 11'(at);
         end
      endcase
      a.live_count = 11'(live_len);
      return a;
   endfunction

   function automatic request_type make_req(input ohte_pkg::op_type op, input logic [31:0] k,
                                            input logic [31:0] h, input logic [31:0] v,
                                            input logic [10:0] c);
      request_type r;
      r.op = op; r.key = k; r.key_hash = h; r.value = v; r.cursor = c;
      return r;
   endfunction

   // Random request; odd keys get a narrow low hash range, so collisions and long probes are frequent
   function automatic request_type random_req();
      logic [31:0] k, h;
      int pick;
      ohte_pkg::op_type op;
      pick = $urandom_range(99);
      if (pick < 45) op = ohte_pkg::OP_INSERT;
      else if (pick < 65) op = ohte_pkg::OP_LOOKUP;
      else if (pick < 85) op = ohte_pkg::OP_DELETE;
      else op = ohte_pkg::OP_ITER;
      if (used_keys.size() > 0 && $urandom_range(2) != 0)
         k = used_keys[$urandom_range(used_keys.size() - 1)];
      else begin
         k = $urandom;
         if (used_keys.size() < 200) used_keys.push_back(k);
      end
      // hash derived from the key so the same key keeps its hash
      h = (k[0]) ? {k[31:8] ^ 24'h5a5a5a, k[7:0] & 8'h1f} : ~k;
      return make_req(op, k, h, $urandom, 11'($urandom_range(40)));
   endfunction

   // Driver: hold the transfer until accepted, idling at random
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && (!req_valid || req_ready)) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            request_type r;
            r = pending_reqs.pop_front();
            expected_answers.push_back(table_apply(r));
            req_valid <= 1;
            req_op <= r.op; req_key <= r.key; req_key_hash <= r.key_hash;
            req_value <= r.value; req_cursor <= r.cursor;
         end else req_valid <= 0;
      end
   end

   // Receiver stalls at random, or holds off for a counted stretch when asked
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_go && !hold_done) begin
         if (hold_count < HOLD_CYCLES) begin
            rsp_ready <= 0;
            hold_count <= hold_count + 1;
         end else begin
            hold_done <= 1;
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
         end else begin
            answer_type e;
            e = expected_answers.pop_front();
            if (rsp_status !== e.status || rsp_found !== e.found ||
                rsp_key_out !== e.key_out || rsp_value_out !== e.value_out ||
                rsp_next_cursor !== e.next_cursor || rsp_live_count !== e.live_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp sts %0d fnd %0d key %h val %h cur %0d live %0d,",
                     e.status, e.found, e.key_out, e.value_out, e.next_cursor, e.live_count,
                     " got sts %0d fnd %0d key %h val %h cur %0d live %0d",
                     rsp_status, rsp_found, rsp_key_out, rsp_value_out, rsp_next_cursor,
                     rsp_live_count);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] k;
      for (int i = 0; i < SLOT_CAP; i++) slots[i] = EMPTY_MARK;
      order_len = 0; live_len = 0; capacity = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed: empty table, extremes, colliding hashes, update, delete, iterate
      pending_reqs.push_back(make_req(ohte_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_DELETE, 32'hffffffff, 32'hffffffff,
                                      32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_ITER, 32'h0, 32'h0, 32'h0, 11'd2047));
      pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, 32'h0, 32'h0, 32'hffffffff, 11'h7ff));
      pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, 32'hffffffff, 32'hffffffff,
                                      32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, 32'h12345678, 32'h0, 32'h1, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, 32'h0, 32'h8, 32'h2, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_LOOKUP, 32'h0, 32'h8, 32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_LOOKUP, 32'h12345678, 32'h0, 32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, 32'h0, 32'h0, 32'haaaa5555, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_DELETE, 32'h12345678, 32'h0, 32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_LOOKUP, 32'h0, 32'h8, 32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_ITER, 32'h0, 32'h0, 32'h0, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_ITER, 32'h0, 32'h0, 32'h0, 11'd2));
      pending_reqs.push_back(make_req(ohte_pkg::OP_ITER, 32'h0, 32'h0, 32'h0, 11'd3));
      pending_reqs.push_back(make_req(ohte_pkg::OP_ITER, 32'h0, 32'h0, 32'h0, 11'd1024));
      pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, 32'h12345678, 32'h0, 32'h3, 11'd0));
      pending_reqs.push_back(make_req(ohte_pkg::OP_LOOKUP, 32'h12345678, 32'h1, 32'h0, 11'd0));
      wait_drained();

      // Pause the sender so everything drains, then refill under receiver hold-off
      pending_reqs.push_back(random_req());
      wait_drained();
      hold_go = 1;
      for (int i = 0; i < 40; i++) pending_reqs.push_back(random_req());
      wait (hold_done);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle_pct = 59; recv_idle_pct = 23; end
         if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         for (int i = 0; i < 170; i++) pending_reqs.push_back(random_req());
         if (phase == 1) begin
            // fill deep to force larger rebuilds and the full answer
            for (int i = 0; i < 560; i++) begin
               k = $urandom;
               pending_reqs.push_back(make_req(ohte_pkg::OP_INSERT, k, $urandom, $urandom,
                                               11'd0));
            end
            for (int i = 0; i < 30; i++)
               pending_reqs.push_back(make_req(ohte_pkg::OP_ITER, 32'h0, 32'h0, 32'h0,
                                               11'($urandom_range(1100))));
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
